// ----- design/gbps_pkg.sv -----
// ----------------------------------------------------------------------------
// Gray bit plane slicer package
// Widths, register indexes, reset values, shared types and the Gray code function for the bit plane slicer.
// ----------------------------------------------------------------------------
package gbps_pkg;

    localparam int PIX_W     = 8;
    localparam int PLANES    = 8;
    localparam int PLANE_W   = 3;
    localparam int DIM_W     = 16;
    localparam int OFF_W     = 29;
    localparam int BASE_W    = 30;
    localparam int RB_W      = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd64;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd64;

    localparam logic [PLANE_W-1:0] LAST_PLANE = 3'd7;

    // One emitted group: its byte offset, the plane size and eight packed plane bytes, plane 0 in the low byte.
    typedef struct packed {
        logic [OFF_W-1:0]            offset;
        logic [OFF_W-1:0]            total;
        logic [PLANES-1:0][PIX_W-1:0] bytes;
    } t_group;

    function automatic logic [PIX_W-1:0] gray_code(input logic [PIX_W-1:0] p);
        return p ^ (p >> 1);
    endfunction

endpackage

// ----- design/gray_bit_plane_slicer.sv -----
// ----------------------------------------------------------------------------
// Gray bit plane slicer
// Packs Gray-coded pixel bits into per-plane bytes for a plane-major writer.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on i_pixel, qualified by i_valid; an item is
// taken at a clock edge where i_valid is high and o_stall is low. Every pixel
// is Gray coded and its eight bits are ORed into eight plane accumulators at
// bit position column mod 8. When a pixel closes a group (column mod 8 is 7,
// or it is the last pixel of a row) the eight bytes are emitted on the result
// channel, plane 0 first, one item per cycle while i_stall is low, each with
// its byte offset in the plane and the plane size. o_last_of_run marks the
// plane 7 byte. Plane 0 of a group is valid in the cycle after the closing
// pixel is taken when the serializer is free; otherwise the group waits in
// the holding register. The block takes one pixel per cycle while o_stall is
// low, and a group yields eight result bytes, so rows whose width is a
// multiple of eight run at full rate. A row that ends in a short group, and
// every row narrower than eight, emits more bytes than it has pixels and is
// limited by the drain of those bytes. o_stall rises only when the holding
// register is full and the next pixel would close another group. When the
// receiver raises i_stall the current result is held unchanged. Reset
// (synchronous, active low) clears the counters and accumulators, sets both
// configuration registers to 64, and empties the result side. The
// configuration port is always ready; write only while the block is idle.
// ----------------------------------------------------------------------------
module gray_bit_plane_slicer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [gbps_pkg::PIX_W-1:0]     i_pixel,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [gbps_pkg::PLANE_W-1:0]   o_plane_index,
    output logic [gbps_pkg::OFF_W-1:0]     o_byte_offset,
    output logic [gbps_pkg::PIX_W-1:0]     o_plane_byte,
    output logic                           o_last_of_run,
    output logic [gbps_pkg::OFF_W-1:0]     o_plane_bytes,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbps_pkg::DIM_W-1:0]     i_cfg_data
);
    import gbps_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    // Scan state.
    logic [DIM_W-1:0]             r_col, n_col;
    logic [DIM_W-1:0]             r_row, n_row;
    logic [BASE_W-1:0]            r_base, n_base;
    logic [PLANES-1:0][PIX_W-1:0] r_acc, n_acc;

    // Result side: serializer and one holding slot.
    t_group             r_ser, n_ser;
    logic               r_ser_valid, n_ser_valid;
    logic [PLANE_W-1:0] r_plane, n_plane;
    t_group             r_pend, n_pend;
    logic               r_pend_valid, n_pend_valid;

    // Combinational helpers.
    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [DIM_W:0]    col_inc, row_inc, rb_wide;
    logic [RB_W-1:0]   row_bytes;
    logic [BASE_W-1:0] total_wide, off_wide;
    logic              row_end, group_end, in_fire, new_grp;
    logic              out_fire, ser_done, ser_free;
    logic [PIX_W-1:0]  gray;
    logic [PLANES-1:0][PIX_W-1:0] merged;
    t_group            grp;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        eff_w      = (r_width  == '0) ? DIM_W'(1) : r_width;
        eff_h      = (r_height == '0) ? DIM_W'(1) : r_height;
        col_inc    = {1'b0, r_col} + (DIM_W+1)'(1);
        row_inc    = {1'b0, r_row} + (DIM_W+1)'(1);
        row_end    = col_inc >= {1'b0, eff_w};
        group_end  = (r_col[2:0] == 3'd7) || row_end;
        // Bytes per row: ceil(width / 8).
        rb_wide    = ({1'b0, eff_w} + (DIM_W+1)'(7)) >> 3;
        row_bytes  = rb_wide[RB_W-1:0];
        total_wide = BASE_W'(row_bytes) * BASE_W'(eff_h);
        off_wide   = r_base + BASE_W'(r_col[DIM_W-1:3]);

        o_stall  = r_pend_valid && group_end;
        in_fire  = i_valid && !o_stall;
        new_grp  = in_fire && group_end;
        out_fire = r_ser_valid && !i_stall;
        ser_done = out_fire && (r_plane == LAST_PLANE);
        ser_free = !r_ser_valid || ser_done;

        // Place each plane bit of this pixel at its column position.
        gray = gray_code(i_pixel);
        for (int k = 0; k < PLANES; k++) begin
            merged[k] = r_acc[k] | (PIX_W'(gray[k]) << r_col[2:0]);
        end

        grp.offset = off_wide[OFF_W-1:0];
        grp.total  = total_wide[OFF_W-1:0];
        grp.bytes  = merged;

        // Scan counters and accumulators.
        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        n_acc  = r_acc;
        if (in_fire) begin
            n_acc = group_end ? '0 : merged;
            if (row_end) begin
                n_col = '0;
                if (row_inc >= {1'b0, eff_h}) begin
                    n_row  = '0;
                    n_base = '0;
                end else begin
                    n_row  = row_inc[DIM_W-1:0];
                    n_base = r_base + BASE_W'(row_bytes);
                end
            end else begin
                n_col = col_inc[DIM_W-1:0];
            end
        end

        // Result side: the serializer shifts its bytes down one plane per item.
        n_ser        = r_ser;
        n_ser_valid  = r_ser_valid;
        n_plane      = r_plane;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (ser_free) begin
            n_plane = '0;
            if (r_pend_valid) begin
                n_ser        = r_pend;
                n_ser_valid  = 1'b1;
                n_pend_valid = new_grp;
                if (new_grp) begin
                    n_pend = grp;
                end
            end else if (new_grp) begin
                n_ser       = grp;
                n_ser_valid = 1'b1;
            end else begin
                n_ser_valid = 1'b0;
            end
        end else begin
            if (out_fire) begin
                n_plane     = r_plane + PLANE_W'(1);
                n_ser.bytes = r_ser.bytes >> PIX_W;
            end
            if (new_grp) begin
                n_pend       = grp;
                n_pend_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_base       <= '0;
            r_acc        <= '0;
            r_ser_valid  <= 1'b0;
            r_plane      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col        <= n_col;
            r_row        <= n_row;
            r_base       <= n_base;
            r_acc        <= n_acc;
            r_ser_valid  <= n_ser_valid;
            r_plane      <= n_plane;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_ser  <= n_ser;
        r_pend <= n_pend;
    end

    assign o_valid       = r_ser_valid;
    assign o_plane_index = r_plane;
    assign o_byte_offset = r_ser.offset;
    assign o_plane_byte  = r_ser.bytes[0];
    assign o_last_of_run = (r_plane == LAST_PLANE);
    assign o_plane_bytes = r_ser.total;

endmodule

// ----- design/gbps_checker.sv -----
// ----------------------------------------------------------------------------
// Gray bit plane slicer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gbps_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [gbps_pkg::PLANE_W-1:0]   o_plane_index,
    input logic [gbps_pkg::OFF_W-1:0]     o_byte_offset,
    input logic [gbps_pkg::PIX_W-1:0]     o_plane_byte,
    input logic                           o_last_of_run,
    input logic [gbps_pkg::OFF_W-1:0]     o_plane_bytes
);
    import gbps_pkg::*;

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_plane_index)
            && $stable(o_byte_offset) && $stable(o_plane_byte)
            && $stable(o_plane_bytes))
        else $error("stalled result changed");

    // The end marker sits on plane 7 and only there.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_run == (o_plane_index == LAST_PLANE)))
        else $error("last_of_run not on plane 7");

    // A group's planes follow each other without gaps, at one offset.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid
            && (o_plane_index == $past(o_plane_index) + PLANE_W'(1))
            && $stable(o_byte_offset))
        else $error("plane sequence broken inside a group");

    // A group that follows straight on a finished one starts with plane 0.
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_of_run |=> !o_valid || (o_plane_index == '0))
        else $error("group does not start at plane 0");

endmodule

bind gray_bit_plane_slicer gbps_checker u_gbps_checker (.*);
